// ----- rtl/core/cnhr_pkg.sv -----
// Shared constants, codes and types for the CR/LF normalizing history ring.
package cnhr_pkg;

    localparam int HISTORY_DEPTH = 128 * 1024;
    localparam int ADDR_W        = $clog2(HISTORY_DEPTH);
    localparam int FILL_W        = ADDR_W + 1;
    localparam int OFFSET_W      = 17;
    localparam int CMP_W         = (OFFSET_W > FILL_W) ? OFFSET_W : FILL_W;
    localparam int BYTE_W        = 8;
    localparam int MODE_W        = 2;
    localparam int S_TDATA_W     = 32;
    localparam int M_TDATA_W     = 32;
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_W    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W    = FIFO_PTR_W + 1;

    localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUT   = 2'd0,
        MODE_CLEAR = 2'd1,
        MODE_READ  = 2'd2
    } t_mode;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last;
        logic              chunk_end;
        logic              read_valid;
        logic [FILL_W-1:0] fill_level;
        logic              wrapped;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result res;
    } t_stage;

endpackage

// ----- rtl/core/cnhr_ram.sv -----
// Single-port-write, single-port-read synchronous RAM with registered read data.
module cnhr_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/cnhr_out_fifo.sv -----
// Small result queue that decouples the ring pipeline from the output stream.
module cnhr_out_fifo (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_push,
    input  cnhr_pkg::t_result                 i_data,
    input  logic                              i_pop,
    output logic                              o_valid,
    output cnhr_pkg::t_result                 o_data,
    output logic [cnhr_pkg::FIFO_CNT_W-1:0]   o_count
);
    import cnhr_pkg::*;

    t_result               r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count;
    logic                  pop_fire;

    assign o_valid  = (r_count != '0);
    assign pop_fire = i_pop && o_valid;
    assign o_data   = r_mem[r_rd_ptr];
    assign o_count  = r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop_fire) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, pop_fire})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- rtl/core/crlf_normalizing_history_ring_core.sv -----
// Top level of the CR/LF normalizing history ring.
//
// Input stream (s_*): one transaction per command. tuser carries the mode
// (put, clear, read), tdata the received byte and the read offset, tlast the
// end-of-chunk mark. Output stream (m_*): one transaction per result; a put
// yields one or two results, clear and read one each, an unused mode none.
// tlast marks the final result of a command, tuser flags a valid read.
// Configuration: i_cfg_wr_en writes i_cfg_wr_data into the auto line-ending
// enable; write it only while the block is idle.
//
// A result passes through the pipeline stage and the result queue to the output.
// Throughput: one command per cycle while the queue and stage have room, except
// a put that inserts a CR or LF, which holds s_tready low while its second byte
// is written, as the history RAM has one write port. Reads use the same RAM.
// Reset clears the write pointer, wrapped flag, previous-CR flag, enable and
// result queue; stored bytes are not cleared and become unreachable.
// When the receiver stalls, results collect in a four-entry queue and s_tready
// drops once the queue and the pipeline stage cannot take another result.
module crlf_normalizing_history_ring_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic                              i_cfg_wr_data,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // [7:0] data_byte, [24:8] read_offset, [31:25] zero
    input  logic [cnhr_pkg::S_TDATA_W-1:0]    i_s_tdata,
    // [1:0] mode
    input  logic [cnhr_pkg::MODE_W-1:0]       i_s_tuser,
    input  logic                              i_s_tlast,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // [7:0] out_byte, [8] chunk_end, [26:9] fill_level, [27] wrapped, [31:28] zero
    output logic [cnhr_pkg::M_TDATA_W-1:0]    o_m_tdata,
    // [0] read_valid
    output logic                              o_m_tuser,
    output logic                              o_m_tlast
);
    import cnhr_pkg::*;

    logic                  r_auto;
    logic [ADDR_W-1:0]     r_wp;
    logic                  r_wrapped;
    logic                  r_prev_cr;
    logic                  r_pend;
    logic [BYTE_W-1:0]     r_pend_byte;
    logic                  r_pend_chunk;
    t_stage                r_p1;

    logic [ADDR_W-1:0]     n_wp;
    logic                  n_wrapped;
    logic                  n_prev_cr;
    logic                  n_pend;
    logic [BYTE_W-1:0]     n_pend_byte;
    logic                  n_pend_chunk;
    t_stage                n_p1;

    logic                  ram_we;
    logic [BYTE_W-1:0]     ram_wdata;
    logic                  ram_re;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [BYTE_W-1:0]     ram_rdata;

    logic [FIFO_CNT_W-1:0] fifo_count;
    logic                  fifo_valid;
    t_result               fifo_in;
    t_result               fifo_out;

    logic                  credit;
    logic                  accept;
    t_mode                 in_mode;
    logic [BYTE_W-1:0]     in_byte;
    logic [OFFSET_W-1:0]   in_offset;

    logic [FILL_W-1:0]     fill_now;
    logic [FILL_W-1:0]     wp_inc;
    logic                  at_end;
    logic [ADDR_W-1:0]     adv_wp;
    logic                  adv_wrapped;
    logic [FILL_W-1:0]     adv_fill;
    logic                  rd_ok;
    logic [FILL_W-1:0]     rd_sum;
    logic [FILL_W-1:0]     rd_idx;
    logic                  is_cr;
    logic                  is_lf;
    logic                  extra;
    logic [BYTE_W-1:0]     ins_byte;

    assign in_mode   = t_mode'(i_s_tuser);
    assign in_byte   = i_s_tdata[BYTE_W-1:0];
    assign in_offset = i_s_tdata[BYTE_W +: OFFSET_W];

    assign credit = ((FIFO_CNT_W + 1)'(fifo_count) + (FIFO_CNT_W + 1)'(r_p1.valid))
                    < (FIFO_CNT_W + 1)'(FIFO_DEPTH);
    assign o_s_tready = !r_pend && credit;
    assign accept     = i_s_tvalid && o_s_tready;

    assign fill_now    = r_wrapped ? FILL_W'(HISTORY_DEPTH) : {1'b0, r_wp};
    assign wp_inc      = {1'b0, r_wp} + 1'b1;
    assign at_end      = (wp_inc == FILL_W'(HISTORY_DEPTH));
    assign adv_wp      = at_end ? '0 : wp_inc[ADDR_W-1:0];
    assign adv_wrapped = r_wrapped || at_end;
    assign adv_fill    = adv_wrapped ? FILL_W'(HISTORY_DEPTH) : {1'b0, adv_wp};

    assign rd_ok  = CMP_W'(in_offset) < CMP_W'(fill_now);
    assign rd_sum = (r_wrapped ? {1'b0, r_wp} : '0) + FILL_W'(in_offset);
    assign rd_idx = (rd_sum >= FILL_W'(HISTORY_DEPTH)) ? rd_sum - FILL_W'(HISTORY_DEPTH)
                                                         : rd_sum;

    assign is_cr    = (in_byte == CHAR_CR);
    assign is_lf    = (in_byte == CHAR_LF);
    assign extra    = is_lf ? !r_prev_cr : r_prev_cr;
    assign ins_byte = is_lf ? CHAR_CR : CHAR_LF;

    always_comb begin
        n_wp         = r_wp;
        n_wrapped    = r_wrapped;
        n_prev_cr    = r_prev_cr;
        n_pend       = r_pend;
        n_pend_byte  = r_pend_byte;
        n_pend_chunk = r_pend_chunk;
        n_p1         = '0;
        ram_we       = 1'b0;
        ram_wdata    = in_byte;
        ram_re       = 1'b0;
        ram_raddr    = rd_idx[ADDR_W-1:0];

        if (r_pend) begin
            if (credit) begin
                ram_we                  = 1'b1;
                ram_wdata               = r_pend_byte;
                n_wp                    = adv_wp;
                n_wrapped               = adv_wrapped;
                n_pend                  = 1'b0;
                n_p1.valid              = 1'b1;
                n_p1.res.out_byte       = r_pend_byte;
                n_p1.res.last           = 1'b1;
                n_p1.res.chunk_end      = r_pend_chunk;
                n_p1.res.fill_level     = adv_fill;
                n_p1.res.wrapped        = adv_wrapped;
            end
        end else if (accept) begin
            unique case (in_mode)
                MODE_PUT: begin
                    ram_we              = 1'b1;
                    n_wp                = adv_wp;
                    n_wrapped           = adv_wrapped;
                    n_p1.valid          = 1'b1;
                    n_p1.res.fill_level = adv_fill;
                    n_p1.res.wrapped    = adv_wrapped;
                    if (r_auto) begin
                        n_prev_cr = is_cr;
                    end
                    if (r_auto && extra) begin
                        ram_wdata         = ins_byte;
                        n_p1.res.out_byte = ins_byte;
                        n_pend            = 1'b1;
                        n_pend_byte       = in_byte;
                        n_pend_chunk      = i_s_tlast;
                    end else begin
                        n_p1.res.out_byte  = in_byte;
                        n_p1.res.last      = 1'b1;
                        n_p1.res.chunk_end = i_s_tlast;
                    end
                end
                MODE_CLEAR: begin
                    n_wp          = '0;
                    n_wrapped     = 1'b0;
                    n_prev_cr     = 1'b0;
                    n_p1.valid    = 1'b1;
                    n_p1.res.last = 1'b1;
                end
                MODE_READ: begin
                    ram_re              = rd_ok;
                    n_p1.valid          = 1'b1;
                    n_p1.res.last       = 1'b1;
                    n_p1.res.read_valid = rd_ok;
                    n_p1.res.fill_level = fill_now;
                    n_p1.res.wrapped    = r_wrapped;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_auto    <= 1'b0;
            r_wp      <= '0;
            r_wrapped <= 1'b0;
            r_prev_cr <= 1'b0;
            r_pend    <= 1'b0;
            r_p1      <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_auto <= i_cfg_wr_data;
            end
            r_wp      <= n_wp;
            r_wrapped <= n_wrapped;
            r_prev_cr <= n_prev_cr;
            r_pend    <= n_pend;
            r_p1      <= n_p1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_byte  <= n_pend_byte;
        r_pend_chunk <= n_pend_chunk;
    end

    cnhr_ram #(
        .DATA_W (BYTE_W),
        .DEPTH  (HISTORY_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wp),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        fifo_in = r_p1.res;
        if (r_p1.res.read_valid) begin
            fifo_in.out_byte = ram_rdata;
        end
    end

    cnhr_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_p1.valid),
        .i_data  (fifo_in),
        .i_pop   (i_m_tready),
        .o_valid (fifo_valid),
        .o_data  (fifo_out),
        .o_count (fifo_count)
    );

    assign o_m_tvalid = fifo_valid;
    assign o_m_tlast  = fifo_out.last;
    assign o_m_tuser  = fifo_out.read_valid;
    assign o_m_tdata  = M_TDATA_W'({fifo_out.wrapped, fifo_out.fill_level,
                                    fifo_out.chunk_end, fifo_out.out_byte});

endmodule

// ----- rtl/core/cnhr_checker.sv -----
// Port-level assertions for the CR/LF normalizing history ring, with bind.
module cnhr_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    input  logic [cnhr_pkg::M_TDATA_W-1:0]    o_m_tdata,
    input  logic                              o_m_tuser,
    input  logic                              o_m_tlast
);
    import cnhr_pkg::*;

    localparam int FILL_LSB = BYTE_W + 1;
    localparam int WRAP_BIT = FILL_LSB + FILL_W;

    a_idle_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid right after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
                                      && $stable(o_m_tlast) && $stable(o_m_tuser))
        else $error("stalled output transaction changed");

    a_read_is_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tlast && !o_m_tdata[BYTE_W])
        else $error("valid read result not a single final result");

    a_wrap_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[WRAP_BIT]
            |-> o_m_tdata[FILL_LSB +: FILL_W] == FILL_W'(HISTORY_DEPTH))
        else $error("wrapped history without full fill level");

    a_chunk_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[BYTE_W] |-> o_m_tlast)
        else $error("chunk end on a result that is not final");

endmodule

bind crlf_normalizing_history_ring_core cnhr_checker u_cnhr_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);

// ----- test/tb_crlf_normalizing_history_ring_core.sv -----
// Self-checking stream testbench for the CR/LF normalizing history ring core.
module tb_crlf_normalizing_history_ring_core;
    import cnhr_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int                TIMEOUT     = 4_000_000;
    localparam int                LONG_HOLD   = 400;

    class normalized_history_sb;
        logic [BYTE_W-1:0] history [HISTORY_DEPTH];
        int unsigned       wr_pos;
        bit                has_wrapped;
        bit                prev_cr;
        bit                auto_le;
        t_result           expected_q[$];
        int                errors;

        function new();
            wr_pos      = 0;
            has_wrapped = 0;
            prev_cr     = 0;
            auto_le     = 0;
            errors      = 0;
        endfunction

        function logic [FILL_W-1:0] fill();
            return has_wrapped ? FILL_W'(HISTORY_DEPTH) : FILL_W'(wr_pos);
        endfunction

        function void emit(logic [BYTE_W-1:0] b, logic last, logic chunk);
            t_result r;
            history[wr_pos] = b;
            wr_pos++;
            if (wr_pos == HISTORY_DEPTH) begin
                wr_pos      = 0;
                has_wrapped = 1;
            end
            r.out_byte   = b;
            r.last       = last;
            r.chunk_end  = chunk;
            r.read_valid = 1'b0;
            r.fill_level = fill();
            r.wrapped    = has_wrapped;
            expected_q.push_back(r);
        endfunction

        function void note_command(logic [MODE_W-1:0] mode, logic [BYTE_W-1:0] b,
                                   logic [OFFSET_W-1:0] offset, logic eoc);
            t_result           r;
            logic [BYTE_W-1:0] ins;
            bit                extra;
            int unsigned       idx;
            ins   = CHAR_LF;
            extra = 0;
            r     = '0;
            r.last = 1'b1;
            if (mode == MODE_PUT) begin
                if (auto_le) begin
                    if (b == CHAR_CR) begin
                        extra   = prev_cr;
                        prev_cr = 1;
                    end else begin
                        if (b == CHAR_LF) begin
                            extra = !prev_cr;
                            ins   = CHAR_CR;
                        end else begin
                            extra = prev_cr;
                        end
                        prev_cr = 0;
                    end
                    if (extra)
                        emit(ins, 1'b0, 1'b0);
                end
                emit(b, 1'b1, eoc);
            end else if (mode == MODE_CLEAR) begin
                wr_pos      = 0;
                has_wrapped = 0;
                prev_cr     = 0;
                expected_q.push_back(r);
            end else if (mode == MODE_READ) begin
                if (offset < fill()) begin
                    idx = (has_wrapped ? wr_pos : 0) + offset;
                    if (idx >= HISTORY_DEPTH)
                        idx -= HISTORY_DEPTH;
                    r.out_byte   = history[idx];
                    r.read_valid = 1'b1;
                end
                r.fill_level = fill();
                r.wrapped    = has_wrapped;
                expected_q.push_back(r);
            end
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] tdata, logic tuser, logic tlast);
            t_result e;
            if (expected_q.size() == 0) begin
                $error("unexpected result tdata=%h tuser=%b tlast=%b", tdata, tuser, tlast);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (tdata[7:0] !== e.out_byte) begin
                $error("out_byte: expected %h, got %h", e.out_byte, tdata[7:0]);
                errors++;
            end
            if (tlast !== e.last) begin
                $error("last: expected %b, got %b", e.last, tlast);
                errors++;
            end
            if (tdata[8] !== e.chunk_end) begin
                $error("chunk_end: expected %b, got %b", e.chunk_end, tdata[8]);
                errors++;
            end
            if (tuser !== e.read_valid) begin
                $error("read_valid: expected %b, got %b", e.read_valid, tuser);
                errors++;
            end
            if (tdata[26:9] !== e.fill_level) begin
                $error("fill_level: expected %0d, got %0d", e.fill_level, tdata[26:9]);
                errors++;
            end
            if (tdata[27] !== e.wrapped) begin
                $error("wrapped: expected %b, got %b", e.wrapped, tdata[27]);
                errors++;
            end
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_wr_en;
    logic                   i_cfg_wr_data;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    logic [S_TDATA_W-1:0]   i_s_tdata;
    logic [MODE_W-1:0]      i_s_tuser;
    logic                   i_s_tlast;
    logic                   o_m_tvalid;
    logic                   i_m_tready;
    logic [M_TDATA_W-1:0]   o_m_tdata;
    logic                   o_m_tuser;
    logic                   o_m_tlast;

    normalized_history_sb   sb;
    bit                     idle_on;
    bit                     hold_output;

    crlf_normalizing_history_ring_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_tvalid    (i_s_tvalid),
        .o_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_s_tuser     (i_s_tuser),
        .i_s_tlast     (i_s_tlast),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata),
        .o_m_tuser     (o_m_tuser),
        .o_m_tlast     (o_m_tlast)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    initial begin
        #TIMEOUT;
        $display("simulation failed");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready)
                sb.note_command(i_s_tuser, i_s_tdata[7:0], i_s_tdata[24:8], i_s_tlast);
            if (o_m_tvalid && i_m_tready)
                sb.check_result(o_m_tdata, o_m_tuser, o_m_tlast);
        end
    end

    initial begin
        i_m_tready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_output) begin
                i_m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_output = 0;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            @(posedge i_clk);
        end
    end

    task automatic send_command(logic [MODE_W-1:0] mode, logic [BYTE_W-1:0] b,
                                logic [OFFSET_W-1:0] offset, logic eoc);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {7'd0, offset, b};
        i_s_tuser  <= mode;
        i_s_tlast  <= eoc;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_auto_line_ending(bit value);
        drain_results();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        sb.auto_le = value;
        i_cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic [BYTE_W-1:0] pick_byte(int cr_pct, int lf_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < cr_pct)
            return CHAR_CR;
        if (roll < cr_pct + lf_pct)
            return CHAR_LF;
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [OFFSET_W-1:0] pick_offset();
        int unsigned f;
        int          roll;
        f    = sb.fill();
        roll = $urandom_range(0, 99);
        if (roll < 50 && f > 0)
            return OFFSET_W'($urandom_range(0, f - 1));
        if (roll < 65)
            return OFFSET_W'(f + $urandom_range(0, 2) - 1);
        return OFFSET_W'($urandom());
    endfunction

    task automatic random_traffic(int count);
        int          roll;
        int unsigned len;
        int          sent;
        sent = 0;
        while (sent < count) begin
            if (sent % 100 == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            roll = $urandom_range(0, 99);
            if (roll < 55) begin
                // text line with a random line ending or none
                len = $urandom_range(0, 6);
                repeat (len) begin
                    send_command(MODE_PUT, BYTE_W'($urandom_range(32, 126)), OFFSET_W'($urandom()),
                                 1'($urandom()));
                    sent++;
                end
                case ($urandom_range(0, 3))
                    0: begin
                        send_command(MODE_PUT, CHAR_CR, OFFSET_W'($urandom()), 1'b0);
                        send_command(MODE_PUT, CHAR_LF, OFFSET_W'($urandom()), 1'($urandom()));
                        sent += 2;
                    end
                    1: begin
                        send_command(MODE_PUT, CHAR_LF, OFFSET_W'($urandom()), 1'($urandom()));
                        sent++;
                    end
                    2: begin
                        send_command(MODE_PUT, CHAR_CR, OFFSET_W'($urandom()), 1'($urandom()));
                        sent++;
                    end
                    default: ;
                endcase
            end else if (roll < 75) begin
                send_command(MODE_PUT, pick_byte(25, 25), OFFSET_W'($urandom()), 1'($urandom()));
                sent++;
            end else if (roll < 93) begin
                send_command(MODE_READ, BYTE_W'($urandom()), pick_offset(), 1'($urandom()));
                sent++;
            end else if (roll < 97) begin
                send_command(MODE_CLEAR, BYTE_W'($urandom()), OFFSET_W'($urandom()),
                             1'($urandom()));
                sent++;
            end else begin
                send_command(MODE_UNUSED, BYTE_W'($urandom()), OFFSET_W'($urandom()),
                             1'($urandom()));
            end
        end
    endtask

    initial begin
        sb            = new();
        idle_on       = 1;
        hold_output   = 0;
        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= 1'b0;
        i_s_tvalid    <= 1'b0;
        i_s_tdata     <= '0;
        i_s_tuser     <= MODE_PUT;
        i_s_tlast     <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_auto_line_ending(1'b1);
        send_command(MODE_PUT, 8'h41, 17'd0, 1'b0);
        send_command(MODE_PUT, CHAR_CR, 17'd0, 1'b0);
        send_command(MODE_PUT, CHAR_CR, 17'd0, 1'b0);
        send_command(MODE_PUT, 8'h42, 17'd0, 1'b0);
        send_command(MODE_PUT, CHAR_LF, 17'd0, 1'b0);
        send_command(MODE_PUT, CHAR_CR, 17'd0, 1'b0);
        send_command(MODE_PUT, CHAR_LF, 17'd0, 1'b1);
        send_command(MODE_PUT, 8'h00, 17'h1FFFF, 1'b1);
        send_command(MODE_PUT, 8'hFF, 17'h1FFFF, 1'b1);
        send_command(MODE_READ, 8'hFF, 17'd0, 1'b1);
        send_command(MODE_READ, 8'h00, 17'd11, 1'b0);
        send_command(MODE_READ, 8'h00, 17'd12, 1'b0);
        send_command(MODE_READ, 8'h00, 17'h1FFFF, 1'b0);
        send_command(MODE_UNUSED, 8'hFF, 17'h1FFFF, 1'b1);
        send_command(MODE_PUT, CHAR_CR, 17'd0, 1'b0);
        write_auto_line_ending(1'b0);
        send_command(MODE_PUT, 8'h61, 17'd0, 1'b0);
        send_command(MODE_PUT, CHAR_LF, 17'd0, 1'b0);
        send_command(MODE_PUT, CHAR_CR, 17'd0, 1'b1);
        write_auto_line_ending(1'b1);
        send_command(MODE_PUT, 8'h62, 17'd0, 1'b0);
        send_command(MODE_CLEAR, 8'hFF, 17'h1FFFF, 1'b1);
        send_command(MODE_READ, 8'h00, 17'd0, 1'b0);
        send_command(MODE_PUT, CHAR_LF, 17'd0, 1'b0);
        send_command(MODE_READ, 8'h00, 17'd0, 1'b0);
        send_command(MODE_READ, 8'h00, 17'd1, 1'b0);

        for (int seg = 0; seg < 4; seg++) begin
            write_auto_line_ending(seg % 2 == 1);
            if (seg % 2 == 0)
                hold_output = 1;
            random_traffic(350);
        end

        // run at full rate to the end
        idle_on = 0;
        drain_results();
        send_command(MODE_READ, 8'h00, 17'd0, 1'b0);
        send_command(MODE_READ, 8'h00, 17'h1FFFF, 1'b0);
        repeat (500) begin
            if ($urandom_range(0, 3) == 0)
                send_command(MODE_PUT, pick_byte(25, 25), OFFSET_W'($urandom()), 1'($urandom()));
            else
                send_command(MODE_READ, BYTE_W'($urandom()), pick_offset(), 1'($urandom()));
        end

        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ----- crlf_normalizing_history_ring_core.f -----
rtl/core/cnhr_pkg.sv
rtl/core/cnhr_ram.sv
rtl/core/cnhr_out_fifo.sv
rtl/core/crlf_normalizing_history_ring_core.sv
rtl/core/cnhr_checker.sv
test/tb_crlf_normalizing_history_ring_core.sv
